[rtl/arpc_pkg.sv]
// package for the arp responder with cache: sizes, codes, state type
// no dependencies
package arpc_pkg;
  localparam int NumPorts = 4;
  localparam int TableEntries = 32;
  localparam int PortW = (NumPorts > 1) ? $clog2(NumPorts) : 1;
  localparam int SlotW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int SlotCntW = $clog2(TableEntries + 1);
  localparam int Slots = NumPorts * TableEntries;
  localparam int AddrW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int EntryW = 32 + 48 + 1;

  localparam logic [1:0] CMD_RX = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY = 16'd2;
  localparam logic [15:0] HTYPE_ETH = 16'd1;
  localparam logic [15:0] PTYPE_IP4 = 16'h0800;
  localparam logic [7:0] HLEN_MAC = 8'd6;
  localparam logic [7:0] IPV4_ADDR_LEN = 8'd4;

  localparam logic [3:0] ST_REQ_ANSWERED = 4'd0;
  localparam logic [3:0] ST_REPLY_LEARNED = 4'd1;
  localparam logic [3:0] ST_SHORT = 4'd2;
  localparam logic [3:0] ST_OTHER_OP = 4'd3;
  localparam logic [3:0] ST_BAD_HW = 4'd4;
  localparam logic [3:0] ST_BAD_PROTO = 4'd5;
  localparam logic [3:0] ST_BAD_HLEN = 4'd6;
  localparam logic [3:0] ST_BAD_PLEN = 4'd7;
  localparam logic [3:0] ST_NOT_MINE = 4'd8;
  localparam logic [3:0] ST_FULL = 4'd9;
  localparam logic [3:0] ST_ADDED = 4'd10;
  localparam logic [3:0] ST_DELETED = 4'd11;
  localparam logic [3:0] ST_DEL_REFUSED = 4'd12;
  localparam logic [3:0] ST_HIT = 4'd13;
  localparam logic [3:0] ST_MISS = 4'd14;

  localparam logic [1:0] CFG_PORT0_MAC = 2'd0;
  localparam logic [1:0] CFG_PORT1_MAC = 2'd1;
  localparam logic [1:0] CFG_PORT2_MAC = 2'd2;
  localparam logic [1:0] CFG_PORT3_MAC = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN1, S_SCAN2, S_WRITE, S_OUT
  } state_t;
endpackage

[rtl/arpc_ram.sv]
// generic single-port-write, single-read ram with registered read data
// no dependencies
module arpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/arp_responder_with_cache_unit.sv]
// top level of the arp responder with cache: control, valid bits, result register
// depends on arpc_pkg and arpc_ram
//
// channel | direction | handshake
// in_     | input     | in_valid / in_stall, one item per transfer
// out_    | output    | out_valid / out_stall, one result per transfer
// cfg_    | input     | cfg_we, cfg_index, cfg_wdata, no wait
//
// per item, one entry read per cycle from the table ram walks the port's slots,
// then one write-back and one load of the result register. header failures skip
// the walk. an answered request walks twice (look up target, then learn sender).
// reset clears the per-entry valid bits at once; no clearing pass.
// a waiting result holds while out_stall is high; the next item is taken
// the cycle after the result transfer, once the result register is free.
module arp_responder_with_cache_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_port_index,
  input  logic        in_too_short,
  input  logic [15:0] in_opcode,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_len,
  input  logic [7:0]  in_proto_len,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_target_ip,
  input  logic [31:0] in_key_ip,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic        out_send_reply,
  output logic [47:0] out_reply_dest_mac,
  output logic [31:0] out_reply_sender_ip,
  output logic [31:0] out_reply_target_ip,
  output logic [47:0] out_found_mac,
  output logic        out_learn_failed
);
  import arpc_pkg::*;

  state_t state_r, state_nxt;

  // port mac registers
  logic [47:0] mac_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) mac_r[i] <= '0;
    end else if (cfg_we) begin
      mac_r[cfg_index] <= cfg_wdata;
    end
  end

  // captured item
  logic [1:0]       cmd_r;
  logic [PortW-1:0] port_r;
  logic             req_r;     // receive of a request
  logic [31:0]      sip_r, tip_r, key_r;
  logic [47:0]      smac_r;

  // walk bookkeeping
  logic [SlotCntW-1:0] rd_cnt_r;   // slot being addressed
  logic [SlotCntW-1:0] chk_cnt_r;  // slot whose data is on the ram output
  logic                chk_v_r;
  logic                hit_r, free_r;
  logic [SlotW-1:0]    hit_slot_r, free_slot_r;
  logic                hit_local_r;
  logic [47:0]         hit_mac_r;
  logic                pass_r;     // 0: first walk, 1: learn walk after an answered request

  logic [Slots-1:0] valid_r;

  // result register
  logic        out_valid_r;
  logic [3:0]  status_r;
  logic        send_r, lfail_r;
  logic [47:0] dmac_r, fmac_r;
  logic [31:0] rsip_r, rtip_r;

  // ram
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  arpc_ram #(.Width(EntryW), .Depth(Slots)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  function automatic logic [AddrW-1:0] slot_addr(input logic [PortW-1:0] p,
                                                 input logic [SlotW-1:0] s);
    return AddrW'(p) * AddrW'(TableEntries) + AddrW'(s);
  endfunction

  // out-of-range port saturates to the last port
  logic [PortW-1:0] in_port;
  assign in_port = (int'(in_port_index) >= NumPorts) ? PortW'(NumPorts - 1)
                                                     : PortW'(in_port_index);

  logic accept;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;

  // header check for receive
  logic [3:0] hdr_st;
  logic       hdr_ok;
  always_comb begin
    hdr_ok = 1'b0;
    hdr_st = ST_SHORT;
    if (in_too_short) hdr_st = ST_SHORT;
    else if (in_opcode != OP_REQUEST && in_opcode != OP_REPLY) hdr_st = ST_OTHER_OP;
    else if (in_hw_type != HTYPE_ETH) hdr_st = ST_BAD_HW;
    else if (in_proto_type != PTYPE_IP4) hdr_st = ST_BAD_PROTO;
    else if (in_hw_len != HLEN_MAC) hdr_st = ST_BAD_HLEN;
    else if (in_proto_len != IPV4_ADDR_LEN) hdr_st = ST_BAD_PLEN;
    else hdr_ok = 1'b1;
  end

  // key compared during the walk
  logic [31:0] walk_key;
  always_comb begin
    if (cmd_r == CMD_RX) walk_key = (req_r && !pass_r) ? tip_r : sip_r;
    else walk_key = key_r;
  end

  logic [AddrW-1:0] chk_addr;
  logic             chk_valid, chk_match;
  assign chk_addr  = slot_addr(port_r, chk_cnt_r[SlotW-1:0]);
  assign chk_valid = valid_r[chk_addr];
  assign chk_match = chk_v_r && chk_valid && (ram_rdata[EntryW-1 -: 32] == walk_key);

  assign ram_raddr = slot_addr(port_r, rd_cnt_r[SlotW-1:0]);

  // learn decision for the write-back
  logic        learn_walk;
  logic        do_learn_upd, do_learn_new;
  logic [47:0] learn_mac;
  logic        learn_local;
  assign learn_walk  = (cmd_r == CMD_RX && (!req_r || pass_r)) || cmd_r == CMD_ADD;
  assign learn_mac   = (cmd_r == CMD_ADD) ? mac_r[port_r] : smac_r;
  assign learn_local = (cmd_r == CMD_ADD);
  assign do_learn_upd = learn_walk && hit_r;
  assign do_learn_new = learn_walk && !hit_r && free_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_addr(port_r, hit_slot_r);
    ram_wdata = {walk_key, learn_mac, hit_local_r};
    if (state_r == S_WRITE) begin
      if (do_learn_upd) begin
        ram_we = 1'b1;
      end else if (do_learn_new) begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(port_r, free_slot_r);
        ram_wdata = {walk_key, learn_mac, learn_local};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = (in_command == CMD_RX && !hdr_ok) ? S_OUT : S_SCAN1;
      S_SCAN1: state_nxt = S_SCAN2;
      S_SCAN2: if (!chk_v_r) state_nxt = S_WRITE;
      S_WRITE: begin
        if (cmd_r == CMD_RX && req_r && !pass_r && hit_r && hit_local_r)
          state_nxt = S_SCAN1;
        else
          state_nxt = S_OUT;
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r  <= in_command;
            port_r <= in_port;
            req_r  <= (in_opcode == OP_REQUEST);
            sip_r  <= in_sender_ip;
            tip_r  <= in_target_ip;
            key_r  <= in_key_ip;
            smac_r <= in_sender_mac;
            pass_r <= 1'b0;
            rd_cnt_r <= '0;
            status_r <= hdr_st;
            send_r <= 1'b0;
            lfail_r <= 1'b0;
            dmac_r <= '0;
            rsip_r <= '0;
            rtip_r <= '0;
            fmac_r <= '0;
          end
        end
        S_SCAN1: begin
          hit_r <= 1'b0;
          free_r <= 1'b0;
          chk_cnt_r <= '0;
          chk_v_r <= 1'b1;
          rd_cnt_r <= SlotCntW'(1);
        end
        S_SCAN2: begin
          if (chk_v_r) begin
            if (chk_match && !hit_r) begin
              hit_r       <= 1'b1;
              hit_slot_r  <= chk_cnt_r[SlotW-1:0];
              hit_local_r <= ram_rdata[0];
              hit_mac_r   <= ram_rdata[48:1];
            end
            if (!chk_valid && !free_r) begin
              free_r      <= 1'b1;
              free_slot_r <= chk_cnt_r[SlotW-1:0];
            end
            chk_cnt_r <= rd_cnt_r;
            chk_v_r   <= (rd_cnt_r != SlotCntW'(TableEntries));
            if (rd_cnt_r != SlotCntW'(TableEntries)) rd_cnt_r <= rd_cnt_r + 1'b1;
          end
        end
        S_WRITE: begin
          rd_cnt_r <= '0;
          if (do_learn_new) valid_r[slot_addr(port_r, free_slot_r)] <= 1'b1;
          case (cmd_r)
            CMD_RX: begin
              if (req_r && !pass_r) begin
                if (hit_r && hit_local_r) begin
                  pass_r   <= 1'b1;
                  status_r <= ST_REQ_ANSWERED;
                  send_r   <= 1'b1;
                  dmac_r   <= smac_r;
                  rsip_r   <= tip_r;
                  rtip_r   <= sip_r;
                end else begin
                  status_r <= ST_NOT_MINE;
                end
              end else if (req_r) begin
                lfail_r <= !(hit_r || free_r);
              end else begin
                status_r <= (hit_r || free_r) ? ST_REPLY_LEARNED : ST_FULL;
                lfail_r  <= !(hit_r || free_r);
              end
            end
            CMD_ADD: status_r <= (hit_r || free_r) ? ST_ADDED : ST_FULL;
            CMD_DEL: begin
              if (hit_r && hit_local_r) begin
                valid_r[slot_addr(port_r, hit_slot_r)] <= 1'b0;
                status_r <= ST_DELETED;
              end else begin
                status_r <= ST_DEL_REFUSED;
              end
            end
            CMD_LOOKUP: begin
              status_r <= hit_r ? ST_HIT : ST_MISS;
              fmac_r   <= hit_r ? hit_mac_r : '0;
            end
            default: status_r <= ST_MISS;
          endcase
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_send_reply      = send_r;
  assign out_reply_dest_mac  = dmac_r;
  assign out_reply_sender_ip = rsip_r;
  assign out_reply_target_ip = rtip_r;
  assign out_found_mac       = fmac_r;
  assign out_learn_failed    = lfail_r;
endmodule

[rtl/arpc_checker.sv]
// port-level checks for the arp responder with cache
// depends on arpc_pkg; bound to arp_responder_with_cache_unit
module arpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_status,
  input logic        out_send_reply,
  input logic [47:0] out_found_mac,
  input logic        out_learn_failed
);
  import arpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_reply_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_reply |-> out_status == ST_REQ_ANSWERED)
    else $error("reply with wrong status");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_HIT |-> out_found_mac == '0)
    else $error("found mac without hit");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result waits");

  a_lfail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_learn_failed |->
      (out_status == ST_REQ_ANSWERED || out_status == ST_FULL))
    else $error("learn failure with wrong status");
endmodule

bind arp_responder_with_cache_unit arpc_checker u_arpc_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_send_reply(out_send_reply), .out_found_mac(out_found_mac),
  .out_learn_failed(out_learn_failed)
);
